// ===== hw/rtl/htc_pkg.sv =====
// ----------------------------------------------------------------------------
// htc_pkg
// shared types, constants and helpers of the homogeneous triangle clipper
// ----------------------------------------------------------------------------
package htc_pkg;

    localparam int MAX_POLY_VERTS  = 10;
    localparam int NUM_PLANES      = 7;
    localparam int ATTR_COMPONENTS = 9;
    localparam int NUM_COMP        = 4 + ATTR_COMPONENTS;
    localparam int CI_W            = $clog2(NUM_COMP);
    localparam int Q_W             = 17;   // unsigned q1.16 weight
    localparam int STEP_W          = $clog2(Q_W);

    // clip planes, in the order a polygon meets them
    localparam logic [2:0] PL_W      = 3'd0;
    localparam logic [2:0] PL_NEAR   = 3'd1;
    localparam logic [2:0] PL_FAR    = 3'd2;
    localparam logic [2:0] PL_LEFT   = 3'd3;
    localparam logic [2:0] PL_RIGHT  = 3'd4;
    localparam logic [2:0] PL_TOP    = 3'd5;
    localparam logic [2:0] PL_BOTTOM = 3'd6;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_w;
        logic [63:0]        color_rgba;
        logic [31:0]        tex_uv;
        logic [47:0]        normal_xyz;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic [63:0]        out_color;
        logic [31:0]        out_uv;
        logic [47:0]        out_normal;
        logic               last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [3:0][31:0]                 pos;
        logic [ATTR_COMPONENTS-1:0][15:0] attr;
    } t_vtx;

    // one item on the chain: a vertex, or the end of a polygon
    typedef struct packed {
        logic eop;
        t_vtx vtx;
    } t_link;

    function automatic t_vtx to_vtx(t_in_item it);
        t_vtx v;
        v.pos[0]  = it.pos_x;
        v.pos[1]  = it.pos_y;
        v.pos[2]  = it.pos_z;
        v.pos[3]  = it.pos_w;
        v.attr[3:0] = it.color_rgba;
        v.attr[5:4] = it.tex_uv;
        v.attr[8:6] = it.normal_xyz;
        return v;
    endfunction

    function automatic t_out_item to_out(t_vtx v, logic last);
        t_out_item o;
        o.out_x       = v.pos[0];
        o.out_y       = v.pos[1];
        o.out_z       = v.pos[2];
        o.out_w       = v.pos[3];
        o.out_color   = v.attr[3:0];
        o.out_uv      = v.attr[5:4];
        o.out_normal  = v.attr[8:6];
        o.last_of_run = last;
        return o;
    endfunction

    function automatic logic signed [33:0] plane_dist(t_vtx v, logic [2:0] pl);
        logic signed [33:0] x, y, z, w, d;
        x = 34'(signed'(v.pos[0]));
        y = 34'(signed'(v.pos[1]));
        z = 34'(signed'(v.pos[2]));
        w = 34'(signed'(v.pos[3]));
        unique case (pl)
            PL_W:      d = w;
            PL_NEAR:   d = w + z;
            PL_FAR:    d = w - z;
            PL_LEFT:   d = w + x;
            PL_RIGHT:  d = w - x;
            PL_TOP:    d = w - y;
            PL_BOTTOM: d = w + y;
            default:   d = w;
        endcase
        return d;
    endfunction

    // component c: positions first, then attributes, sign extended
    function automatic logic signed [33:0] get_comp(t_vtx v, logic [CI_W-1:0] c);
        logic [CI_W-1:0]    ai;
        logic signed [33:0] r;
        ai = c - CI_W'(4);
        if (c < CI_W'(4)) begin
            r = 34'(signed'(v.pos[c[1:0]]));
        end else begin
            r = 34'(signed'(v.attr[ai]));
        end
        return r;
    endfunction

    function automatic t_vtx set_comp(t_vtx v, logic [CI_W-1:0] c, logic [33:0] val);
        t_vtx            o;
        logic [CI_W-1:0] ai;
        o  = v;
        ai = c - CI_W'(4);
        if (c < CI_W'(4)) begin
            o.pos[c[1:0]] = val[31:0];
        end else begin
            o.attr[ai] = val[15:0];
        end
        return o;
    endfunction

    function automatic logic [33:0] sat_comp(logic signed [35:0] r, logic is_pos);
        logic signed [35:0] hi, lo, s;
        hi = is_pos ? 36'sd2147483647 : 36'sd32767;
        lo = is_pos ? -36'sd2147483648 : -36'sd32768;
        s  = (r > hi) ? hi : ((r < lo) ? lo : r);
        return s[33:0];
    endfunction

endpackage

// ===== hw/rtl/htc_cell.sv =====
// ----------------------------------------------------------------------------
// htc_cell
// one clip plane: gathers a polygon, then replays it against the plane
// ----------------------------------------------------------------------------
module htc_cell #(
    parameter int         MAX_VERTS = htc_pkg::MAX_POLY_VERTS,
    parameter logic [2:0] PLANE     = htc_pkg::PL_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  htc_pkg::t_link i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output htc_pkg::t_link o_item
);

    localparam int IW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
    localparam int CW = $clog2(MAX_VERTS + 1);

    localparam logic [3:0] S_COLLECT = 4'd0;
    localparam logic [3:0] S_LOAD    = 4'd1;
    localparam logic [3:0] S_TEST    = 4'd2;
    localparam logic [3:0] S_DIV     = 4'd3;
    localparam logic [3:0] S_MUL     = 4'd4;
    localparam logic [3:0] S_ADD     = 4'd5;
    localparam logic [3:0] S_EMITX   = 4'd6;
    localparam logic [3:0] S_EMITC   = 4'd7;
    localparam logic [3:0] S_NEXT    = 4'd8;
    localparam logic [3:0] S_END     = 4'd9;

    logic [3:0]                  r_state;
    htc_pkg::t_vtx               r_buf [MAX_VERTS];
    logic [CW-1:0]               r_n, r_k, r_ocnt;
    htc_pkg::t_vtx               r_prev, r_cur, r_xv;
    logic                        r_cin;
    logic [34:0]                 r_rem, r_den;
    logic [htc_pkg::Q_W-1:0]     r_q;
    logic [htc_pkg::STEP_W-1:0]  r_step;
    logic [htc_pkg::CI_W-1:0]    r_c;
    logic signed [51:0]          r_prod;
    logic signed [33:0]          r_a;
    logic                        r_ovld;
    htc_pkg::t_link              r_oitem;

    logic signed [33:0] w_dc, w_dp, w_ca, w_cb, w_diff;
    logic               w_cin, w_pin, w_ge, w_free, w_drop, w_ld;
    logic [33:0]        w_ma, w_mb, w_sat;
    logic [34:0]        w_den, w_rsub;
    logic signed [17:0] w_t;
    logic [51:0]        w_pabs, w_qm;
    logic signed [51:0] w_q;
    logic signed [35:0] w_res;
    htc_pkg::t_link     w_lditem;

    assign w_dc   = htc_pkg::plane_dist(r_cur, PLANE);
    assign w_dp   = htc_pkg::plane_dist(r_prev, PLANE);
    assign w_cin  = ~w_dc[33];
    assign w_pin  = ~w_dp[33];
    assign w_ma   = w_dp[33] ? 34'(-w_dp) : 34'(w_dp);
    assign w_mb   = w_dc[33] ? 34'(-w_dc) : 34'(w_dc);
    assign w_den  = 35'(w_ma) + 35'(w_mb);

    // restoring division, one weight bit per cycle
    assign w_ge   = (r_rem >= r_den);
    assign w_rsub = w_ge ? (r_rem - r_den) : r_rem;

    // interpolation, one component at a time
    assign w_ca   = htc_pkg::get_comp(r_prev, r_c);
    assign w_cb   = htc_pkg::get_comp(r_cur, r_c);
    assign w_diff = w_cb - w_ca;
    assign w_t    = signed'({1'b0, r_q});
    assign w_pabs = r_prod[51] ? 52'(-r_prod) : 52'(r_prod);
    assign w_qm   = (w_pabs + 52'd32768) >> 16;
    assign w_q    = r_prod[51] ? -signed'(w_qm) : signed'(w_qm);
    assign w_res  = 36'(r_a) + 36'(w_q);
    assign w_sat  = htc_pkg::sat_comp(w_res, r_c < htc_pkg::CI_W'(4));

    assign w_free = !r_ovld || i_ready;
    assign w_drop = (r_ocnt >= CW'(MAX_VERTS));

    always_comb begin
        w_ld            = 1'b0;
        w_lditem.eop    = 1'b0;
        w_lditem.vtx    = r_cur;
        case (r_state)
            S_EMITX: begin
                w_ld         = w_free && !w_drop;
                w_lditem.vtx = r_xv;
            end
            S_EMITC: w_ld = w_free && !w_drop;
            S_END: begin
                w_ld         = w_free;
                w_lditem.eop = 1'b1;
            end
            default: w_ld = 1'b0;
        endcase
    end

    assign o_ready = (r_state == S_COLLECT);
    assign o_valid = r_ovld;
    assign o_item  = r_oitem;

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_oitem <= w_lditem;
        end
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
            r_n     <= '0;
            r_ovld  <= 1'b0;
        end else begin
            if (w_ld) begin
                r_ovld <= 1'b1;
            end else if (i_ready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_COLLECT: begin
                    if (i_valid) begin
                        if (i_item.eop) begin
                            r_k     <= '0;
                            r_ocnt  <= '0;
                            r_state <= (r_n == '0) ? S_END : S_LOAD;
                        end else if (r_n < CW'(MAX_VERTS)) begin
                            r_buf[r_n[IW-1:0]] <= i_item.vtx;
                            r_n                <= r_n + 1'b1;
                            r_prev             <= i_item.vtx;
                        end
                    end
                end
                S_LOAD: begin
                    r_cur   <= r_buf[r_k[IW-1:0]];
                    r_state <= S_TEST;
                end
                S_TEST: begin
                    r_cin <= w_cin;
                    if (w_cin != w_pin) begin
                        r_rem   <= 35'(w_ma);
                        r_den   <= w_den;
                        r_q     <= '0;
                        r_step  <= '0;
                        r_c     <= '0;
                        r_state <= (w_den == '0) ? S_MUL : S_DIV;
                    end else begin
                        r_state <= w_cin ? S_EMITC : S_NEXT;
                    end
                end
                S_DIV: begin
                    r_rem  <= {w_rsub[33:0], 1'b0};
                    r_q    <= {r_q[htc_pkg::Q_W-2:0], w_ge};
                    r_step <= r_step + 1'b1;
                    if (r_step == htc_pkg::STEP_W'(htc_pkg::Q_W - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_diff * w_t;
                    r_a     <= w_ca;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_xv <= htc_pkg::set_comp(r_xv, r_c, w_sat);
                    if (r_c == htc_pkg::CI_W'(htc_pkg::NUM_COMP - 1)) begin
                        r_state <= S_EMITX;
                    end else begin
                        r_c     <= r_c + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_EMITX: begin
                    if (w_free || w_drop) begin
                        if (!w_drop) begin
                            r_ocnt <= r_ocnt + 1'b1;
                        end
                        r_state <= r_cin ? S_EMITC : S_NEXT;
                    end
                end
                S_EMITC: begin
                    if (w_free || w_drop) begin
                        if (!w_drop) begin
                            r_ocnt <= r_ocnt + 1'b1;
                        end
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_prev <= r_cur;
                    if (r_k + 1'b1 == r_n) begin
                        r_state <= S_END;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_LOAD;
                    end
                end
                S_END: begin
                    if (w_free) begin
                        r_n     <= '0;
                        r_state <= S_COLLECT;
                    end
                end
                default: r_state <= S_COLLECT;
            endcase
        end
    end

endmodule

// ===== hw/rtl/htc_fan.sv =====
// ----------------------------------------------------------------------------
// htc_fan
// gathers the clipped polygon and sends it out as a triangle fan
// ----------------------------------------------------------------------------
module htc_fan #(
    parameter int MAX_VERTS = htc_pkg::MAX_POLY_VERTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  htc_pkg::t_link     i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output htc_pkg::t_out_item o_item
);

    localparam int IW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
    localparam int CW = $clog2(MAX_VERTS + 1);

    localparam logic F_COLLECT = 1'b0;
    localparam logic F_EMIT    = 1'b1;

    logic               r_state;
    htc_pkg::t_vtx      r_buf [MAX_VERTS];
    logic [CW-1:0]      r_n, r_j;
    logic [1:0]         r_s;
    logic               r_ovld;
    htc_pkg::t_out_item r_oitem;

    logic [CW-1:0] w_idx;
    logic          w_last, w_free;

    // fan order: v0, v(j+1), v(j+2)
    assign w_idx   = (r_s == 2'd0) ? '0 : (r_j + CW'(r_s));
    assign w_last  = (r_s == 2'd2) && (r_j + CW'(3) == r_n);
    assign w_free  = !r_ovld || i_ready;
    assign o_ready = (r_state == F_COLLECT);
    assign o_valid = r_ovld;
    assign o_item  = r_oitem;

    always_ff @(posedge i_clk) begin
        if (r_state == F_EMIT && w_free) begin
            r_oitem <= htc_pkg::to_out(r_buf[w_idx[IW-1:0]], w_last);
        end
        if (!i_rst_n) begin
            r_state <= F_COLLECT;
            r_n     <= '0;
            r_ovld  <= 1'b0;
        end else begin
            if (r_state == F_EMIT && w_free) begin
                r_ovld <= 1'b1;
            end else if (i_ready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                F_COLLECT: begin
                    if (i_valid) begin
                        if (i_item.eop) begin
                            r_j <= '0;
                            r_s <= 2'd0;
                            if (r_n >= CW'(3)) begin
                                r_state <= F_EMIT;
                            end else begin
                                r_n <= '0;
                            end
                        end else if (r_n < CW'(MAX_VERTS)) begin
                            r_buf[r_n[IW-1:0]] <= i_item.vtx;
                            r_n                <= r_n + 1'b1;
                        end
                    end
                end
                F_EMIT: begin
                    if (w_free) begin
                        if (r_s == 2'd2) begin
                            r_s <= 2'd0;
                            if (w_last) begin
                                r_n     <= '0;
                                r_state <= F_COLLECT;
                            end else begin
                                r_j <= r_j + 1'b1;
                            end
                        end else begin
                            r_s <= r_s + 1'b1;
                        end
                    end
                end
                default: r_state <= F_COLLECT;
            endcase
        end
    end

endmodule

// ===== hw/rtl/homogeneous_triangle_clipper.sv =====
// ----------------------------------------------------------------------------
// homogeneous_triangle_clipper
// clips clip-space triangles against the view volume, emits triangle fans
// ----------------------------------------------------------------------------
// Vertices arrive one item at a time, three per triangle. Each triangle walks
// a row of seven plane cells (w>=0, near, far, left, right, top, bottom); each
// cell first gathers the whole polygon from its left neighbor, then replays it
// against its plane and hands the clipped vertices on, closed by an end mark.
// In a cell each vertex is loaded, tested, handed on if it lies inside the plane
// and then passed (load, test, hand on, advance). Every edge that crosses a
// plane adds a restoring division for the weight (skipped when both distances
// are zero), a shared multiply and round over each of the 13 components in turn
// and a step to hand the new vertex on. A cell gathers each vertex and then the
// end mark, and sends its own end mark on after the last vertex; the slowest
// cell, plus any wait on the next cell, bounds how soon the next triangle can
// enter. The cells work on different triangles at the same time. The clipped
// polygon goes out as 3*(n-2) items, one per cycle while the receiver is ready,
// the last one marked with last_of_run; a polygon of fewer than three vertices
// yields no item.
// ----------------------------------------------------------------------------
module homogeneous_triangle_clipper #(
    parameter int MAX_POLY_VERTS = htc_pkg::MAX_POLY_VERTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  htc_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output htc_pkg::t_out_item o_item
);

    localparam int NP = htc_pkg::NUM_PLANES;

    // vertices held for the triangle being gathered
    logic [1:0] r_vcnt;
    // third vertex taken, end mark still to be sent into the chain
    logic       r_end_pend;

    // chain links: link 0 feeds the first cell, link NP feeds the fan stage
    logic           w_lv [NP+1];
    logic           w_lr [NP+1];
    htc_pkg::t_link w_lk [NP+1];

    logic w_acc;

    assign w_acc       = i_valid && o_ready;
    assign o_ready     = w_lr[0] && !r_end_pend;
    assign w_lv[0]     = i_valid || r_end_pend;
    assign w_lk[0].eop = r_end_pend;
    assign w_lk[0].vtx = htc_pkg::to_vtx(i_item);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt     <= 2'd0;
            r_end_pend <= 1'b0;
        end else begin
            if (w_acc) begin
                if (r_vcnt == 2'd2) begin
                    // triangle complete: close the polygon next
                    r_vcnt     <= 2'd0;
                    r_end_pend <= 1'b1;
                end else begin
                    r_vcnt <= r_vcnt + 1'b1;
                end
            end else if (r_end_pend && w_lr[0]) begin
                r_end_pend <= 1'b0;
            end
        end
    end

    // one cell per clip plane, each handing its output to the next
    for (genvar g = 0; g < NP; g++) begin : g_cell
        htc_cell #(
            .MAX_VERTS (MAX_POLY_VERTS),
            .PLANE     (3'(g))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_lv[g]),
            .o_ready (w_lr[g]),
            .i_item  (w_lk[g]),
            .o_valid (w_lv[g+1]),
            .i_ready (w_lr[g+1]),
            .o_item  (w_lk[g+1])
        );
    end

    // fan out of the fully clipped polygon
    htc_fan #(
        .MAX_VERTS (MAX_POLY_VERTS)
    ) u_fan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_lv[NP]),
        .o_ready (w_lr[NP]),
        .i_item  (w_lk[NP]),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

`ifndef SYNTH
    a_end_after_third: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_vcnt == 2'd2) |=> r_end_pend)
        else $error("end mark not scheduled after third vertex");
    a_pend_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_end_pend |-> (r_vcnt == 2'd0))
        else $error("vertex count not cleared while end mark pending");
    a_pend_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_end_pend) |-> ($past(r_vcnt) == 2'd2))
        else $error("end mark raised without a full triangle");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the homogeneous triangle clipper
// ----------------------------------------------------------------------------
// Sends clip-space vertices, three per triangle, and keeps its own model of the
// seven-plane clip. Each triangle is turned into the fan items it should emit.
// Every item that leaves the block is compared field by field with the oldest
// item still expected. Directed triangles come first: inside, outside, crossing,
// extreme values and wide polygons. Random triangles follow, most of them near
// the view volume, and both sides stall in random bursts.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ONE       = 65536;
    localparam int WATCH_MAX = 20000;

    typedef struct {
        longint p[4];
        longint a[htc_pkg::ATTR_COMPONENTS];
    } t_clip_vtx;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    htc_pkg::t_in_item  i_item;
    logic               o_valid;
    logic               i_ready;
    htc_pkg::t_out_item o_item;

    homogeneous_triangle_clipper i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    htc_pkg::t_out_item fan_queue[$];
    t_clip_vtx tri_verts[3];
    int        vert_slot;
    int        errors;
    int        tris_sent;
    int        fan_checked;
    bit        stall_on;
    int        quiet_cycles;
    int        mark_count [9];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // model of the clip
    // ------------------------------------------------------------------------
    function automatic longint plane_distance(t_clip_vtx v, logic [2:0] pl);
        case (pl)
            htc_pkg::PL_W:      return v.p[3];
            htc_pkg::PL_NEAR:   return v.p[3] + v.p[2];
            htc_pkg::PL_FAR:    return v.p[3] - v.p[2];
            htc_pkg::PL_LEFT:   return v.p[3] + v.p[0];
            htc_pkg::PL_RIGHT:  return v.p[3] - v.p[0];
            htc_pkg::PL_TOP:    return v.p[3] - v.p[1];
            default:            return v.p[3] + v.p[1];
        endcase
    endfunction

    // a + round((b - a) * t), half away from zero, then clamped
    function automatic longint blend(longint a, longint b, longint t, bit is_pos);
        longint p;
        longint q;
        longint r;
        p = (b - a) * t;
        q = (p >= 0) ? (p + 32768) / ONE : -((-p + 32768) / ONE);
        r = a + q;
        if (is_pos) begin
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
        end else begin
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
        end
        return r;
    endfunction

    function automatic t_clip_vtx cross_vertex(t_clip_vtx va, t_clip_vtx vb,
                                               longint da, longint db);
        t_clip_vtx r;
        longint    ma;
        longint    mb;
        longint    t;
        ma = (da >= 0) ? da : -da;
        mb = (db >= 0) ? db : -db;
        t  = (ma + mb == 0) ? 0 : (ma << 16) / (ma + mb);
        if (t > ONE) t = ONE;
        for (int c = 0; c < 4; c++) r.p[c] = blend(va.p[c], vb.p[c], t, 1'b1);
        for (int c = 0; c < htc_pkg::ATTR_COMPONENTS; c++)
            r.a[c] = blend(va.a[c], vb.a[c], t, 1'b0);
        return r;
    endfunction

    function automatic htc_pkg::t_out_item fan_item(t_clip_vtx v, bit last);
        htc_pkg::t_out_item o;
        o.out_x = 32'(v.p[0]);
        o.out_y = 32'(v.p[1]);
        o.out_z = 32'(v.p[2]);
        o.out_w = 32'(v.p[3]);
        for (int c = 0; c < 4; c++) o.out_color[16*c +: 16] = 16'(v.a[c]);
        for (int c = 0; c < 2; c++) o.out_uv[16*c +: 16] = 16'(v.a[4+c]);
        for (int c = 0; c < 3; c++) o.out_normal[16*c +: 16] = 16'(v.a[6+c]);
        o.last_of_run = last;
        return o;
    endfunction

    // sutherland-hodgman over all planes, then the fan goes to the queue
    task automatic clip_triangle();
        t_clip_vtx src[$];
        t_clip_vtx dst[$];
        longint    dc;
        longint    dp;
        int        n;
        int        prev;
        int        ntri;
        src = {tri_verts[0], tri_verts[1], tri_verts[2]};
        for (int pl = 0; pl < htc_pkg::NUM_PLANES; pl++) begin
            dst = {};
            n   = src.size();
            for (int k = 0; k < n; k++) begin
                prev = (k + n - 1) % n;
                dc   = plane_distance(src[k], 3'(pl));
                dp   = plane_distance(src[prev], 3'(pl));
                if ((dc >= 0) != (dp >= 0) && dst.size() < htc_pkg::MAX_POLY_VERTS)
                    dst = {dst, cross_vertex(src[prev], src[k], dp, dc)};
                if (dc >= 0 && dst.size() < htc_pkg::MAX_POLY_VERTS)
                    dst = {dst, src[k]};
            end
            src = dst;
        end
        n = src.size();
        mark_count[(n < 3) ? 0 : n - 2]++;
        if (n < 3) return;
        ntri = n - 2;
        for (int j = 0; j < ntri; j++) begin
            fan_queue = {fan_queue, fan_item(src[0], 1'b0)};
            fan_queue = {fan_queue, fan_item(src[j+1], 1'b0)};
            fan_queue = {fan_queue, fan_item(src[j+2], j == ntri - 1)};
        end
    endtask

    task automatic store_vertex(htc_pkg::t_in_item it);
        t_clip_vtx v;
        v.p[0] = it.pos_x;
        v.p[1] = it.pos_y;
        v.p[2] = it.pos_z;
        v.p[3] = it.pos_w;
        for (int c = 0; c < 4; c++) v.a[c] = $signed(it.color_rgba[16*c +: 16]);
        for (int c = 0; c < 2; c++) v.a[4+c] = $signed(it.tex_uv[16*c +: 16]);
        for (int c = 0; c < 3; c++) v.a[6+c] = $signed(it.normal_xyz[16*c +: 16]);
        tri_verts[vert_slot] = v;
        if (vert_slot == 2) begin
            vert_slot = 0;
            tris_sent++;
            clip_triangle();
        end else begin
            vert_slot++;
        end
    endtask

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------
    // one item, with a random gap in front of it while stalls are on
    task automatic send_vertex(htc_pkg::t_in_item it);
        @(negedge i_clk);
        if (stall_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (!o_ready);
        store_vertex(it);
    endtask

    function automatic htc_pkg::t_in_item make_vertex(int x, int y, int z, int w);
        htc_pkg::t_in_item it;
        it.pos_x      = x;
        it.pos_y      = y;
        it.pos_z      = z;
        it.pos_w      = w;
        it.color_rgba = {$urandom, $urandom};
        it.tex_uv     = $urandom;
        it.normal_xyz = {16'($urandom), $urandom};
        return it;
    endfunction

    task automatic send_triangle(int x0, int y0, int z0, int w0,
                                 int x1, int y1, int z1, int w1,
                                 int x2, int y2, int z2, int w2);
        send_vertex(make_vertex(x0, y0, z0, w0));
        send_vertex(make_vertex(x1, y1, z1, w1));
        send_vertex(make_vertex(x2, y2, z2, w2));
    endtask

    // receiver stalls in bursts
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_on && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        htc_pkg::t_out_item exp_item;
        if (i_rst_n && o_valid && i_ready) begin
            if (fan_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected item, expected none, actual %h", $realtime, o_item);
            end else begin
                exp_item = fan_queue.pop_front();
                fan_checked++;
                if (exp_item !== o_item) begin
                    errors++;
                    $display("%0t: mismatch expected x=%h y=%h z=%h w=%h c=%h uv=%h n=%h l=%b",
                             $realtime, exp_item.out_x, exp_item.out_y, exp_item.out_z,
                             exp_item.out_w, exp_item.out_color, exp_item.out_uv,
                             exp_item.out_normal, exp_item.last_of_run);
                    $display("%0t:          actual x=%h y=%h z=%h w=%h c=%h uv=%h n=%h l=%b",
                             $realtime, o_item.out_x, o_item.out_y, o_item.out_z,
                             o_item.out_w, o_item.out_color, o_item.out_uv,
                             o_item.out_normal, o_item.last_of_run);
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCH_MAX) begin
            $display("%0t: watchdog expired, %0d items still expected",
                     $realtime, fan_queue.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_inside();
        send_triangle(0, 0, 0, ONE, ONE/2, 0, 0, ONE, 0, ONE/2, ONE/4, ONE);
        send_triangle(-ONE, -ONE, -ONE, ONE, ONE, -ONE, ONE, ONE, 0, ONE, 0, ONE);
    endtask

    // whole triangle behind the eye, and one wholly beyond the right plane
    task automatic test_outside();
        send_triangle(0, 0, 0, -ONE, ONE, 0, 0, -ONE, 0, ONE, 0, -2*ONE);
        send_triangle(3*ONE, 0, 0, ONE, 4*ONE, ONE, 0, ONE, 5*ONE, 0, 0, ONE);
    endtask

    task automatic test_crossing();
        send_triangle(0, 0, -2*ONE, ONE, ONE/2, 0, 0, ONE, 0, ONE/2, 0, ONE);
        send_triangle(0, 0, 0, ONE, 0, 0, 0, -ONE, ONE/2, ONE/2, 0, ONE);
        send_triangle(-3*ONE, -3*ONE, 0, ONE, 3*ONE, -3*ONE, 0, ONE, 0, 4*ONE, 0, ONE);
        send_triangle(-4*ONE, -4*ONE, -3*ONE, ONE, 5*ONE, -2*ONE, 3*ONE, ONE,
                      -ONE, 5*ONE, 2*ONE, ONE);
    endtask

    // field extremes, all ones and all zeros in the attributes
    task automatic test_extremes();
        htc_pkg::t_in_item it;
        it = '1;
        it.pos_w = 32'sh7fffffff;
        send_vertex(it);
        it = '0;
        it.pos_x = 32'sh80000000;
        it.pos_y = 32'sh7fffffff;
        it.pos_z = 32'sh80000000;
        it.pos_w = 32'sh7fffffff;
        send_vertex(it);
        it = '1;
        it.pos_x = 32'sh7fffffff;
        it.pos_z = 32'sh7fffffff;
        it.pos_w = 32'sh80000000;
        send_vertex(it);
        send_triangle(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                      32'sh7fffffff, 0, 32'sh80000000, 32'sh80000000,
                      0, 32'sh7fffffff, 0, 32'sh7fffffff);
    endtask

    function automatic int rand_near(int w);
        return $signed($urandom_range(0, 6 * w)) - 3 * w;
    endfunction

    task automatic test_random(int count);
        int w;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_vertex(make_vertex($urandom, $urandom, $urandom, $urandom));
            end else begin
                w = $urandom_range(1, 4 * ONE);
                if ($urandom_range(0, 7) == 0) w = -w;
                if (w > 0)
                    send_vertex(make_vertex(rand_near(w), rand_near(w), rand_near(w), w));
                else
                    send_vertex(make_vertex(rand_near(-w), rand_near(-w), rand_near(-w), w));
            end
            if (i == count - 60) stall_on = 1'b0;
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_item      = '0;
        vert_slot   = 0;
        errors      = 0;
        tris_sent   = 0;
        fan_checked = 0;
        stall_on    = 1'b1;
        quiet_cycles = 0;
        foreach (mark_count[k]) mark_count[k] = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_inside();
        test_outside();
        test_crossing();
        test_extremes();
        test_random(357);

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (fan_queue.size() == 0);
        repeat (200) @(posedge i_clk);

        $display("%0d triangles sent, %0d fan items checked, %0d culled to nothing",
                 tris_sent, fan_checked, mark_count[0]);
        $display("fans of 1..7 triangles: %0d %0d %0d %0d %0d %0d %0d", mark_count[1],
                 mark_count[2], mark_count[3], mark_count[4], mark_count[5],
                 mark_count[6], mark_count[7]);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
